>>> src/homogeneous_point_transform_unit_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_UNIT_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_UNIT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define HPT_ASSERT_NOW(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("hpt assertion failed");

// Condition implies consequence in the next cycle.
`define HPT_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("hpt assertion failed");

`endif

>>> src/hpt_pkg.sv
package hpt_pkg;

  localparam int CoordW  = 32;
  localparam int WideW   = 50;
  localparam int ProdW   = 64;
  localparam int SumW    = 66;
  localparam int NumW    = WideW + 16;
  localparam int CmpW    = WideW + 32;
  localparam int DivBits = 32;
  localparam int NumRegs = 8;
  localparam int CfgIdxW = 4;
  localparam int CfgW    = 64;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [WideW-1:0]  wide_t;
  typedef logic [CfgW-1:0]          cfg_word_t;

  // Command codes carried in tuser.
  localparam logic CmdPoint  = 1'b0;
  localparam logic CmdVector = 1'b1;

  // One in Q16.16, and the clamp bounds.
  localparam coord_t OneQ    = 32'sh0001_0000;
  localparam coord_t CoordMax = 32'sh7FFF_FFFF;
  localparam coord_t CoordMin = 32'sh8000_0000;

  // Reset matrix is the identity.
  localparam cfg_word_t MatReset [NumRegs] = '{
    64'h0000_0000_0001_0000, 64'h0,
    64'h0001_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_0001_0000,
    64'h0,                   64'h0001_0000_0000_0000
  };

  // Divider lane input: sign of the result and the two magnitudes.
  typedef struct packed {
    logic             neg;
    logic [WideW-1:0] mv;
    logic [WideW-1:0] mw;
  } div_in_t;

  // Divider lane output: quotient, sign, and quotient too large for 32 bits.
  typedef struct packed {
    logic               big;
    logic               neg;
    logic [DivBits-1:0] q;
  } div_res_t;

endpackage

>>> src/hpt_dot.sv
module hpt_dot (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic                in_cmd,
  input  hpt_pkg::coord_t     in_x,
  input  hpt_pkg::coord_t     in_y,
  input  hpt_pkg::coord_t     in_z,
  input  hpt_pkg::cfg_word_t  mat [hpt_pkg::NumRegs],
  output logic                out_valid,
  output logic                out_cmd,
  output hpt_pkg::wide_t      dot [4]
);

  hpt_pkg::coord_t ent [4][4];
  hpt_pkg::coord_t pt [3];
  logic signed [hpt_pkg::ProdW-1:0] prod [4][3];
  hpt_pkg::coord_t tcol [4];
  logic vld_a;
  logic cmd_a;

  assign pt[0] = in_x;
  assign pt[1] = in_y;
  assign pt[2] = in_z;

  // Unpack the matrix entries from the register words.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        ent[r][c] = (c % 2 == 1) ? mat[r*2 + c/2][63:32] : mat[r*2 + c/2][31:0];
      end
    end
  end

  // Stage A: the twelve products, and the translation column.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (en) begin
      vld_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_a <= in_cmd;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= ent[r][c] * pt[c];
        end
        tcol[r] <= (in_cmd == hpt_pkg::CmdVector) ? '0 : ent[r][3];
      end
    end
  end

  // Stage B: exact sum, then floor to Q34.16.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [hpt_pkg::SumW-1:0] s;
    if (en) begin
      out_cmd <= cmd_a;
      for (int r = 0; r < 4; r++) begin
        s = hpt_pkg::SumW'(prod[r][0]) + hpt_pkg::SumW'(prod[r][1])
          + hpt_pkg::SumW'(prod[r][2]) + (hpt_pkg::SumW'(tcol[r]) <<< 16);
        dot[r] <= s[hpt_pkg::SumW-1:16];
      end
    end
  end

endmodule

>>> src/hpt_div.sv
module hpt_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  hpt_pkg::div_in_t   lane_in [3],
  output logic               out_valid,
  output hpt_pkg::div_res_t  res [3]
);

  localparam int NS = hpt_pkg::DivBits + 1;

  logic                         vld [NS];
  logic [hpt_pkg::NumW-1:0]     rem [NS][3];
  logic [hpt_pkg::WideW-1:0]    dvs [NS][3];
  logic [hpt_pkg::DivBits-1:0]  quo [NS][3];
  logic                         neg [NS][3];
  logic                         big [NS][3];

  // Stage 0: numerator is the magnitude in Q34.32; flag quotients of 2^32 or more.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        rem[0][l] <= {lane_in[l].mv, 16'b0};
        dvs[0][l] <= lane_in[l].mw;
        quo[0][l] <= '0;
        neg[0][l] <= lane_in[l].neg;
        big[0][l] <= {16'b0, lane_in[l].mv, 16'b0} >= {lane_in[l].mw, 32'b0};
      end
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar j = 1; j < NS; j++) begin : g_step
    localparam int K = hpt_pkg::DivBits - j;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      logic [hpt_pkg::CmpW-1:0] sh;
      logic [hpt_pkg::CmpW-1:0] rx;
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          sh = hpt_pkg::CmpW'(dvs[j-1][l]) << K;
          rx = hpt_pkg::CmpW'(rem[j-1][l]);
          if (rx >= sh) begin
            rem[j][l]    <= rem[j-1][l] - sh[hpt_pkg::NumW-1:0];
            quo[j][l]    <= quo[j-1][l] | (hpt_pkg::DivBits'(1) << K);
          end else begin
            rem[j][l]    <= rem[j-1][l];
            quo[j][l]    <= quo[j-1][l];
          end
          dvs[j][l] <= dvs[j-1][l];
          neg[j][l] <= neg[j-1][l];
          big[j][l] <= big[j-1][l];
        end
      end
    end
  end

  assign out_valid = vld[NS-1];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      res[l].big = big[NS-1][l];
      res[l].neg = neg[NS-1][l];
      res[l].q   = quo[NS-1][l];
    end
  end

endmodule

>>> src/homogeneous_point_transform_unit.sv
// Transforms one point or direction per clock by a 4x4 Q16.16 matrix held in eight
// 64-bit registers, with perspective divide for points whose w is neither 0 nor 1.0.
// In order, a word goes through the products and sums, the setup of the divide, the
// bit-per-stage quotient pipeline that every word passes through, and the clamp.
// A new word is taken every cycle unless the output word is stalled,
// which holds the whole pipeline. Write the matrix only while the pipeline is empty.
`include "homogeneous_point_transform_unit_macros.svh"

module homogeneous_point_transform_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [95:0]                      s_tdata,   // in_x, in_y, in_z
  input  logic                             s_tuser,   // cmd
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [95:0]                      m_tdata,   // out_x, out_y, out_z
  output logic                             m_tuser,   // saturated
  input  logic                             cfg_we,
  input  logic [hpt_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [hpt_pkg::CfgW-1:0]         cfg_data
);

  hpt_pkg::cfg_word_t mat [hpt_pkg::NumRegs];
  logic en;
  logic dot_valid;
  logic dot_cmd;
  hpt_pkg::wide_t dot [4];
  logic prep_valid;
  hpt_pkg::div_in_t prep [3];
  logic div_valid;
  hpt_pkg::div_res_t res [3];
  logic out_sat;
  logic at_bound;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Matrix registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hpt_pkg::NumRegs; i++) begin
        mat[i] <= hpt_pkg::MatReset[i];
      end
    end else if (cfg_we && cfg_index < hpt_pkg::CfgIdxW'(hpt_pkg::NumRegs)) begin
      mat[cfg_index[2:0]] <= cfg_data;
    end
  end

  hpt_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_cmd    (s_tuser),
    .in_x      (s_tdata[31:0]),
    .in_y      (s_tdata[63:32]),
    .in_z      (s_tdata[95:64]),
    .mat       (mat),
    .out_valid (dot_valid),
    .out_cmd   (dot_cmd),
    .dot       (dot)
  );

  // Divide setup. Without a divide the divisor is 1.0, so the quotient is the value.
  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (en) begin
      prep_valid <= dot_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic do_div;
    hpt_pkg::wide_t w;
    hpt_pkg::wide_t v;
    if (en) begin
      w = dot[3];
      do_div = (dot_cmd == hpt_pkg::CmdPoint) && (w != '0)
            && (w != hpt_pkg::WideW'(hpt_pkg::OneQ));
      for (int l = 0; l < 3; l++) begin
        v = dot[l];
        prep[l].neg <= do_div ? (v[hpt_pkg::WideW-1] ^ w[hpt_pkg::WideW-1])
                              : v[hpt_pkg::WideW-1];
        prep[l].mv  <= v[hpt_pkg::WideW-1] ? -v : v;
        prep[l].mw  <= do_div ? (w[hpt_pkg::WideW-1] ? -w : w)
                              : hpt_pkg::WideW'(hpt_pkg::OneQ);
      end
    end
  end

  hpt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prep_valid),
    .lane_in   (prep),
    .out_valid (div_valid),
    .res       (res)
  );

  // Sign and clamp into the output word.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic sat;
    hpt_pkg::coord_t c;
    if (en) begin
      sat = 1'b0;
      for (int l = 0; l < 3; l++) begin
        if (res[l].neg) begin
          if (res[l].big || res[l].q > 32'h8000_0000) begin
            c = hpt_pkg::CoordMin;
            sat = 1'b1;
          end else begin
            c = -res[l].q;
          end
        end else begin
          if (res[l].big || res[l].q > 32'h7FFF_FFFF) begin
            c = hpt_pkg::CoordMax;
            sat = 1'b1;
          end else begin
            c = res[l].q;
          end
        end
        m_tdata[l*32 +: 32] <= c;
      end
      out_sat <= sat;
    end
  end

  assign m_tuser = out_sat;

  // Whether any coordinate of the output word sits at a clamp bound.
  always_comb begin
    at_bound = 1'b0;
    for (int l = 0; l < 3; l++) begin
      if ((m_tdata[l*32 +: 32] == hpt_pkg::CoordMax)
          || (m_tdata[l*32 +: 32] == hpt_pkg::CoordMin)) begin
        at_bound = 1'b1;
      end
    end
  end

  // A saturated word has at least one coordinate at a bound.
  `HPT_ASSERT_NOW(a_sat_bound, m_tvalid && m_tuser, at_bound)
  // An overflowing quotient always reaches the flag.
  `HPT_ASSERT_NEXT(a_big_flags, en && div_valid && (res[0].big || res[1].big || res[2].big), m_tvalid && m_tuser)
  // A stall holds the setup stage.
  `HPT_ASSERT_NEXT(a_stall_hold, !en, $stable(prep_valid) && $stable(prep[0].mv))

endmodule
